>>> rtl/mbtcp_pkg.sv
`timescale 1ns / 1ps
package mbtcp_pkg;

	// Header layout: bytes 0..1 transaction id, 2..3 protocol id, 4..5 length,
	// byte 6 unit id, then PDU bytes from position 7 on.
	localparam logic [2:0] POS_TID_HI  = 3'd0;
	localparam logic [2:0] POS_TID_LO  = 3'd1;
	localparam logic [2:0] POS_PID_HI  = 3'd2;
	localparam logic [2:0] POS_PID_LO  = 3'd3;
	localparam logic [2:0] POS_UNIT_ID = 3'd6;
	localparam logic [2:0] POS_PDU     = 3'd7;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic CHK_CRC = 1'b0;
	localparam logic CHK_LRC = 1'b1;

	// Result queue: one request may push up to three results
	localparam int QDEPTH    = 4;
	localparam int QIDX_W    = 2;
	localparam int QCNT_W    = 3;
	localparam int MAX_PUSH  = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic        rejected;
		logic [15:0] transaction_id;
	} out_item_t;

	// Fold one byte into the reflected Modbus CRC-16
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/modbus_tcp_to_serial_frame.sv
`timescale 1ns / 1ps
// Results of an accepted request are registered into the result queue.
// Throughput: one byte per cycle while in_stall is low; the final byte of a frame
// pushes up to three results into a four-entry result queue, and input is taken
// only while the queue holds at most one entry, so input stalls until it drains.
// Reset (arst_n low, asynchronous): frame state, transaction id, checksum mode
// and the result queue are cleared; queue payload entries are not reset.
module modbus_tcp_to_serial_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbtcp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mbtcp_pkg::out_item_t out_data
);
	import mbtcp_pkg::*;

	logic              mode_q;
	logic [2:0]        pos_q;
	logic              bad_q;
	logic [15:0]       tid_q;
	logic [15:0]       crc_q;
	logic [7:0]        lrc_q;

	out_item_t         queue_q [QDEPTH];
	logic [QIDX_W-1:0] wr_q;
	logic [QIDX_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	logic              in_acc;
	logic              pop;
	logic [7:0]        b;
	logic              emit;
	logic              reject;
	logic [15:0]       tid_nx;
	logic              bad_nx;
	logic [15:0]       crc_nx;
	logic [7:0]        lrc_nx;
	logic [1:0]        push_n;
	out_item_t         res [MAX_PUSH];

	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign in_stall  = (cnt_q > QCNT_W'(QDEPTH - MAX_PUSH));
	assign out_data  = queue_q[rd_q];
	assign b         = in_data.in_byte;

	// Decode the header position and build the results of this request
	always_comb begin
		tid_nx = tid_q;
		bad_nx = bad_q;
		unique case (pos_q)
			POS_TID_HI: tid_nx = {b, tid_q[7:0]};
			POS_TID_LO: tid_nx = {tid_q[15:8], b};
			POS_PID_HI, POS_PID_LO: bad_nx = bad_q || (b != 8'h00);
			default: ;
		endcase
		emit   = (pos_q >= POS_UNIT_ID) && !bad_q;
		crc_nx = emit ? crc16_byte(crc_q, b) : crc_q;
		lrc_nx = emit ? (lrc_q + b) : lrc_q;
		reject = (pos_q < POS_UNIT_ID) || bad_q;

		res[0] = '{out_byte: b, out_last: 1'b0, rejected: 1'b0, transaction_id: tid_nx};
		res[1] = res[0];
		res[2] = res[0];
		push_n = emit ? 2'd1 : 2'd0;
		if (in_data.in_last) begin
			if (reject) begin
				res[0] = '{out_byte: 8'h00, out_last: 1'b1, rejected: 1'b1,
					transaction_id: tid_nx};
				push_n = 2'd1;
			end else if (mode_q == CHK_LRC) begin
				res[1].out_byte = 8'h00 - lrc_nx;
				res[1].out_last = 1'b1;
				push_n = 2'd2;
			end else begin
				res[1].out_byte = crc_nx[7:0];
				res[2].out_byte = crc_nx[15:8];
				res[2].out_last = 1'b1;
				push_n = 2'd3;
			end
		end
	end

	// Hold configuration and frame state; clear frame state on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= CHK_CRC;
			pos_q  <= POS_TID_HI;
			bad_q  <= 1'b0;
			tid_q  <= '0;
			crc_q  <= CRC_INIT;
			lrc_q  <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_acc) begin
				tid_q <= tid_nx;
				if (in_data.in_last) begin
					pos_q <= POS_TID_HI;
					bad_q <= 1'b0;
					crc_q <= CRC_INIT;
					lrc_q <= '0;
				end else begin
					pos_q <= (pos_q == POS_PDU) ? POS_PDU : pos_q + 3'd1;
					bad_q <= bad_nx;
					crc_q <= crc_nx;
					lrc_q <= lrc_nx;
				end
			end
		end
	end

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (in_acc) begin
				wr_q <= wr_q + QIDX_W'(push_n);
			end
			if (pop) begin
				rd_q <= rd_q + QIDX_W'(1);
			end
			cnt_q <= cnt_q + (in_acc ? QCNT_W'(push_n) : '0) - (pop ? QCNT_W'(1) : '0);
		end
	end

	// Write the results of an accepted request into the queue
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MAX_PUSH; i++) begin
				if (2'(i) < push_n) begin
					queue_q[wr_q + QIDX_W'(i)] <= res[i];
				end
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count exceeds depth");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (cnt_q <= QCNT_W'(QDEPTH - MAX_PUSH)))
		else $error("request accepted without room for its results");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + ($past(in_acc) ? QCNT_W'($past(push_n)) : '0)
			- ($past(pop) ? QCNT_W'(1) : '0))
		else $error("result queue count out of step with pushes and pops");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.in_last) |=> (pos_q == POS_TID_HI) && !bad_q && (crc_q == CRC_INIT))
		else $error("frame state not cleared after final byte");

endmodule
